>>> rtl/core/lsra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_pkg: shared types, constants and helpers
// Types and sizing for the linear scan register allocator unit.
// ----------------------------------------------------------------------------
package lsra_pkg;

    // Sizing
    localparam int MAX_REGS    = 64;
    localparam int MAX_INSTR   = 4096;
    localparam int FIELD_W     = 12;
    localparam int OUT_REG_W   = 6;
    localparam int IDX_W       = $clog2(MAX_REGS);
    localparam int CNT_W       = $clog2(MAX_REGS + 1);
    localparam int INSTR_LIM   = (MAX_INSTR < (1 << FIELD_W)) ? MAX_INSTR : (1 << FIELD_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Input transaction
    typedef struct packed {
        logic               first_of_run;
        logic [FIELD_W-1:0] interval_start;
        logic [FIELD_W-1:0] interval_end;
        logic [FIELD_W-1:0] interval_tag;
    } t_item;

    // Output transaction
    typedef struct packed {
        logic [FIELD_W-1:0]   result_tag;
        logic [OUT_REG_W-1:0] assigned_register;
        logic                 overflow;
        logic                 order_error;
    } t_result;

    // Classified command handed from front to back
    typedef struct packed {
        logic               first_of_run;
        logic [FIELD_W-1:0] start_time;
        logic [FIELD_W-1:0] end_time;
        logic [FIELD_W-1:0] tag;
        logic               order_error;
    } t_cmd;

    // Queue push side
    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_push;

    // One active list entry
    typedef struct packed {
        logic [FIELD_W-1:0] end_time;
        logic [IDX_W-1:0]   reg_num;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_FINISH
    } t_back_state;

    // Saturate an instruction index to the supported range
    function automatic logic [FIELD_W-1:0] clamp_instr(input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] res;
        res = v;
        if (32'(v) >= 32'(INSTR_LIM)) begin
            res = FIELD_W'(INSTR_LIM - 1);
        end
        return res;
    endfunction

    // Circular index step down
    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] res;
        if (x == '0) begin
            res = IDX_W'(MAX_REGS - 1);
        end else begin
            res = x - 1'b1;
        end
        return res;
    endfunction

    // Circular index step up
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] res;
        if (x == IDX_W'(MAX_REGS - 1)) begin
            res = '0;
        end else begin
            res = x + 1'b1;
        end
        return res;
    endfunction

    // Low bits of a register number for the result field
    function automatic logic [OUT_REG_W-1:0] reg_to_out(input logic [IDX_W-1:0] x);
        logic [31:0] wide;
        wide = 32'(x);
        return wide[OUT_REG_W-1:0];
    endfunction

endpackage

>>> rtl/core/lsra_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lsra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/lsra_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_front: input acceptance and classification
// Saturates the interval bounds, checks start order, forms a command.
// ----------------------------------------------------------------------------
module lsra_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lsra_pkg::t_item i_item,
    input  logic            i_q_full,
    output logic            o_stall,
    output lsra_pkg::t_q_push o_q
);

    logic [lsra_pkg::FIELD_W-1:0] r_prev_start;
    logic [lsra_pkg::FIELD_W-1:0] n_prev_start;
    logic [lsra_pkg::FIELD_W-1:0] start_c;
    logic                         accept;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign start_c = lsra_pkg::clamp_instr(i_item.interval_start);

    // Classify the transaction
    always_comb begin
        o_q.push             = accept;
        o_q.cmd.first_of_run = i_item.first_of_run;
        o_q.cmd.start_time   = start_c;
        o_q.cmd.end_time     = lsra_pkg::clamp_instr(i_item.interval_end);
        o_q.cmd.tag          = i_item.interval_tag;
        // a new run restarts the order check
        o_q.cmd.order_error  = !i_item.first_of_run && (start_c < r_prev_start);
        n_prev_start         = accept ? start_c : r_prev_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_start <= '0;
        end else begin
            r_prev_start <= n_prev_start;
        end
    end

endmodule

>>> rtl/core/lsra_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_queue: command queue between front and back
// Small register FIFO so that either side can stall on its own.
// ----------------------------------------------------------------------------
module lsra_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsra_pkg::t_q_push i_q,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output lsra_pkg::t_cmd    o_cmd
);

    lsra_pkg::t_cmd               r_mem [lsra_pkg::QUEUE_DEPTH];
    logic [lsra_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [lsra_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [lsra_pkg::Q_CNT_W-1:0] r_cnt;
    logic [lsra_pkg::Q_PTR_W-1:0] n_wr_ptr;
    logic [lsra_pkg::Q_PTR_W-1:0] n_rd_ptr;
    logic [lsra_pkg::Q_CNT_W-1:0] n_cnt;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_cnt == lsra_pkg::Q_CNT_W'(lsra_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_q.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == lsra_pkg::Q_PTR_W'(lsra_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == lsra_pkg::Q_PTR_W'(lsra_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_q.cmd;
        end
    end

endmodule

>>> rtl/core/lsra_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_back: expiry scan and register assignment
// The active list is a circular region ending at the tail pointer. The scan
// walks it from the tail down, one RAM read per cycle, pushes expired
// registers on the free stack and rewrites survivors in place toward the
// tail, so the list stays contiguous and keeps its order.
// ----------------------------------------------------------------------------
module lsra_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  lsra_pkg::t_cmd    i_q_cmd,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output lsra_pkg::t_result o_result
);

    localparam int IDX_W = lsra_pkg::IDX_W;
    localparam int CNT_W = lsra_pkg::CNT_W;

    lsra_pkg::t_back_state r_state, n_state;
    lsra_pkg::t_cmd        r_cmd, n_cmd;
    logic [IDX_W-1:0]      r_tail, n_tail;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0]      r_left, n_left;
    logic [CNT_W-1:0]      r_surv, n_surv;
    logic [IDX_W-1:0]      r_rp, n_rp;
    logic [IDX_W-1:0]      r_wp, n_wp;
    logic                  r_pend, n_pend;
    logic                  r_out_valid, n_out_valid;
    lsra_pkg::t_result     r_out, n_out;

    // RAM ports
    logic                          act_wr_en, act_rd_en;
    logic [IDX_W-1:0]              act_wr_addr, act_rd_addr;
    lsra_pkg::t_entry              act_wr_data, act_rd_data;
    logic                          free_wr_en, free_rd_en;
    logic [IDX_W-1:0]              free_wr_addr, free_rd_addr;
    logic [IDX_W-1:0]              free_wr_data, free_rd_data;

    logic             slot_free;
    logic             expired;
    logic             ovf;
    logic [IDX_W-1:0] new_reg;
    logic [CNT_W-1:0] free_dec;

    assign slot_free = !r_out_valid || !i_stall;
    assign expired   = (act_rd_data.end_time <= r_cmd.start_time);
    assign ovf       = (r_count >= CNT_W'(lsra_pkg::MAX_REGS));
    assign free_dec  = r_free_cnt - 1'b1;
    assign new_reg   = (r_free_cnt != '0) ? free_rd_data : r_count[IDX_W-1:0];

    lsra_ram #(
        .WIDTH (lsra_pkg::ENTRY_W),
        .DEPTH (lsra_pkg::MAX_REGS)
    ) u_active_ram (
        .i_clk     (i_clk),
        .i_wr_en   (act_wr_en),
        .i_wr_addr (act_wr_addr),
        .i_wr_data (act_wr_data),
        .i_rd_en   (act_rd_en),
        .i_rd_addr (act_rd_addr),
        .o_rd_data (act_rd_data)
    );

    lsra_ram #(
        .WIDTH (IDX_W),
        .DEPTH (lsra_pkg::MAX_REGS)
    ) u_free_ram (
        .i_clk     (i_clk),
        .i_wr_en   (free_wr_en),
        .i_wr_addr (free_wr_addr),
        .i_wr_data (free_wr_data),
        .i_rd_en   (free_rd_en),
        .i_rd_addr (free_rd_addr),
        .o_rd_data (free_rd_data)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsra_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = lsra_pkg::ST_SCAN;
                end
            end
            lsra_pkg::ST_SCAN: begin
                if (r_left == '0 && !r_pend) begin
                    n_state = lsra_pkg::ST_POP;
                end
            end
            lsra_pkg::ST_POP: begin
                n_state = lsra_pkg::ST_FINISH;
            end
            lsra_pkg::ST_FINISH: begin
                if (slot_free) begin
                    n_state = lsra_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lsra_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        n_cmd        = r_cmd;
        n_tail       = r_tail;
        n_count      = r_count;
        n_free_cnt   = r_free_cnt;
        n_left       = r_left;
        n_surv       = r_surv;
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_pend       = 1'b0;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_stall;
        o_q_pop      = 1'b0;
        act_wr_en    = 1'b0;
        act_wr_addr  = r_wp;
        act_wr_data  = act_rd_data;
        act_rd_en    = 1'b0;
        act_rd_addr  = r_rp;
        free_wr_en   = 1'b0;
        free_wr_addr = r_free_cnt[IDX_W-1:0];
        free_wr_data = act_rd_data.reg_num;
        free_rd_en   = 1'b0;
        free_rd_addr = free_dec[IDX_W-1:0];

        case (r_state)
            lsra_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_rp    = lsra_pkg::idx_dec(r_tail);
                    n_wp    = lsra_pkg::idx_dec(r_tail);
                    n_surv  = '0;
                    // start of a run drops the whole allocation state
                    if (i_q_cmd.first_of_run) begin
                        n_count    = '0;
                        n_free_cnt = '0;
                        n_left     = '0;
                    end else begin
                        n_left     = r_count;
                    end
                end
            end
            lsra_pkg::ST_SCAN: begin
                // issue the next read, newest entry first
                if (r_left != '0) begin
                    act_rd_en = 1'b1;
                    n_rp      = lsra_pkg::idx_dec(r_rp);
                    n_left    = r_left - 1'b1;
                    n_pend    = 1'b1;
                end
                // retire the entry read last cycle
                if (r_pend) begin
                    if (expired) begin
                        if (r_free_cnt < CNT_W'(lsra_pkg::MAX_REGS)) begin
                            free_wr_en = 1'b1;
                            n_free_cnt = r_free_cnt + 1'b1;
                        end
                    end else begin
                        act_wr_en = 1'b1;
                        n_wp      = lsra_pkg::idx_dec(r_wp);
                        n_surv    = r_surv + 1'b1;
                    end
                end
                if (r_left == '0 && !r_pend) begin
                    n_count = r_surv;
                end
            end
            lsra_pkg::ST_POP: begin
                free_rd_en = (r_free_cnt != '0);
            end
            lsra_pkg::ST_FINISH: begin
                if (slot_free) begin
                    n_out_valid           = 1'b1;
                    n_out.result_tag      = r_cmd.tag;
                    n_out.overflow        = ovf;
                    n_out.order_error     = r_cmd.order_error;
                    n_out.assigned_register = ovf ? '0 : lsra_pkg::reg_to_out(new_reg);
                    if (!ovf) begin
                        act_wr_en            = 1'b1;
                        act_wr_addr          = r_tail;
                        act_wr_data.end_time = r_cmd.end_time;
                        act_wr_data.reg_num  = new_reg;
                        n_tail               = lsra_pkg::idx_inc(r_tail);
                        n_count              = r_count + 1'b1;
                        if (r_free_cnt != '0) begin
                            n_free_cnt = free_dec;
                        end
                    end
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsra_pkg::ST_IDLE;
            r_tail      <= '0;
            r_count     <= '0;
            r_free_cnt  <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_free_cnt  <= n_free_cnt;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_surv <= n_surv;
        r_rp   <= n_rp;
        r_wp   <= n_wp;
        r_out  <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

>>> rtl/core/linear_scan_register_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_unit: register allocator top level
// The back end takes a command from the queue, scans the active list for
// expired entries, reads the free stack and writes the result; the scan
// reads no entry when the active list is empty or the interval starts a
// run. The time per interval is set by the expiry scan, which reads the
// active list RAM one entry per cycle through its single read port. A
// stalled result holds the back end in its finish state. A two-entry command
// queue lets the front accept and check intervals while the back end is
// scanning, and the result register lets a new interval start while the
// previous result waits downstream.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  lsra_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output lsra_pkg::t_result o_result
);

    lsra_pkg::t_q_push q_push;
    lsra_pkg::t_cmd    q_cmd;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    // Accept and classify
    lsra_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_stall  (o_stall),
        .o_q      (q_push)
    );

    // Decoupling queue
    lsra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q_push),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Scan and assign
    lsra_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (o_result)
    );

endmodule

>>> rtl/core/lsra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_checker: port level checks
// Watches the top level ports of the allocator over time.
// ----------------------------------------------------------------------------
module lsra_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input lsra_pkg::t_result o_result
);

    // Stalled result stays presented
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // Stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_result))
        else $error("result changed while stalled");

    // An unallocated interval reports register zero
    a_ovf_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.overflow |-> o_result.assigned_register == '0)
        else $error("overflow with nonzero register");

    // Reset empties the result register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    // Reset empties the command queue, so input is open
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

endmodule

bind linear_scan_register_allocator_unit lsra_checker u_lsra_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);

>>> test/tb_linear_scan_register_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_scan_register_allocator_unit: self-checking allocator testbench
// A table of hand-picked intervals runs first: reset state, field extremes,
// out-of-order starts, first-of-run clears, a full active list and a full
// release. Random runs of well-formed intervals follow, mixed with noise and
// broken sequences. Both sides idle at random. Every result transaction is
// compared with an in-order queue filled by a cycle-free allocation model.
// ----------------------------------------------------------------------------
module tb_linear_scan_register_allocator_unit;
    import lsra_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_WAIT  = 2 * (MAX_REGS + 4);
    localparam int MAX_SHOWN    = 10;
    localparam int FIELD_TOP    = (1 << FIELD_W) - 1;
    localparam int PLAN_ROWS    = 17;

    // Receiver stall patterns
    typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    // Random stimulus run kinds
    typedef enum {RUN_SHORT, RUN_LONG, RUN_NOISE, RUN_BROKEN, RUN_DRAIN} t_run_kind;

    // One row of the directed table
    typedef struct {
        bit                 first;
        logic [FIELD_W-1:0] start_at;
        logic [FIELD_W-1:0] end_at;
        logic [FIELD_W-1:0] tag;
        int                 rep;
        bit                 typed_ok;
        t_result            typed;
    } t_plan_row;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    o_stall;
    t_item   i_item  = '0;
    logic    o_valid;
    logic    i_stall = 1'b0;
    t_result o_result;

    linear_scan_register_allocator_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    // Allocation model state
    logic [FIELD_W-1:0] live_end  [MAX_REGS];
    logic [IDX_W-1:0]   live_reg  [MAX_REGS];
    logic [IDX_W-1:0]   spare_reg [MAX_REGS];
    int                 live_cnt   = 0;
    int                 spare_cnt  = 0;
    logic [FIELD_W-1:0] last_start = '0;

    // Results still owed by the block, oldest first
    t_result pending_results[$];

    int items_sent      = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int overflow_seen   = 0;
    int order_err_seen  = 0;
    int hold_asked      = 0;
    int hold_served     = 0;
    int drains          = 0;
    int steady_left     = 0;
    int burst_left      = 0;
    int cycle_count     = 0;

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count,
                     pending_results.size());
            $display("tb_linear_scan_register_allocator_unit: FAIL");
            $finish;
        end
    end

    // Expire, then allocate one interval; updates the model state
    function automatic void allocate_interval(input t_item it, output t_result res);
        logic [FIELD_W-1:0] s;
        logic [IDX_W-1:0]   chosen;
        bit                 ovf;
        bit                 ord;
        int                 i;
        int                 k;
        s = (int'(it.interval_start) >= MAX_INSTR) ? FIELD_W'(MAX_INSTR - 1)
                                                   : it.interval_start;
        chosen = '0;
        ovf = 1'b0;
        if (it.first_of_run) begin
            live_cnt   = 0;
            spare_cnt  = 0;
            last_start = '0;
        end
        ord = s < last_start;
        last_start = s;
        // walk back from the newest entry, keep survivors in order
        for (i = live_cnt - 1; i >= 0; i--) begin
            if (live_end[i] <= s) begin
                if (spare_cnt < MAX_REGS) begin
                    spare_reg[spare_cnt] = live_reg[i];
                    spare_cnt++;
                end
                for (k = i; k < live_cnt - 1; k++) begin
                    live_end[k] = live_end[k + 1];
                    live_reg[k] = live_reg[k + 1];
                end
                live_cnt--;
            end
        end
        if (live_cnt >= MAX_REGS) begin
            ovf = 1'b1;
        end else begin
            if (spare_cnt > 0) begin
                spare_cnt--;
                chosen = spare_reg[spare_cnt];
            end else begin
                chosen = IDX_W'(live_cnt);
            end
            live_end[live_cnt] = (int'(it.interval_end) >= MAX_INSTR) ?
                                 FIELD_W'(MAX_INSTR - 1) : it.interval_end;
            live_reg[live_cnt] = chosen;
            live_cnt++;
        end
        res.result_tag        = it.interval_tag;
        res.assigned_register = OUT_REG_W'(chosen);
        res.overflow          = ovf;
        res.order_error       = ord;
    endfunction

    // Offer one interval, wait for acceptance, then pace the next one
    task automatic send_interval(input t_item it, input bit typed_ok, input t_result typed);
        t_result pred;
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        allocate_interval(it, pred);
        pending_results.push_back(typed_ok ? typed : pred);
        items_sent++;
        if (steady_left != 0) begin
            steady_left--;
        end else if (burst_left != 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // Receiver: changing stall patterns plus requested long hold-offs
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        bit       stall_now;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                RX_FREE:  stall_now = 1'b0;
                RX_LIGHT: stall_now = ($urandom_range(0, 3) == 0);
                RX_HEAVY: stall_now = ($urandom_range(0, 3) != 0);
                default:  stall_now = (mode_left % 3 == 0);
            endcase
            if (hold_left != 0) begin
                hold_left--;
                stall_now = 1'b1;
            end
            i_stall <= stall_now;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("unexpected result transaction: tag %h reg %0d ovf %b ord %b",
                             o_result.result_tag, o_result.assigned_register,
                             o_result.overflow, o_result.order_error);
                end
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.overflow) overflow_seen++;
                if (want.order_error) order_err_seen++;
                if (o_result.result_tag !== want.result_tag ||
                    o_result.assigned_register !== want.assigned_register ||
                    o_result.overflow !== want.overflow ||
                    o_result.order_error !== want.order_error) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("mismatch at result %0d: want tag %h reg %0d ovf %b ord %b,",
                                 results_checked, want.result_tag,
                                 want.assigned_register, want.overflow, want.order_error);
                        $display("    got tag %h reg %0d ovf %b ord %b",
                                 o_result.result_tag, o_result.assigned_register,
                                 o_result.overflow, o_result.order_error);
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_plan_row plan[PLAN_ROWS];
        t_item     it;
        t_run_kind kind;
        int        k;
        int        pick;
        int        run_len;
        int        cur_start;
        int        end_val;
        int        random_goal;
        bit        hold_done;
        bit        drain_done;

        // first, start, end, tag, repeat, typed, typed result
        plan = '{
            // reset state: first register handed out is 0
            '{1'b1, 12'd0,    12'd0,    12'h000, 1,  1'b1, '{12'h000, 6'd0, 1'b0, 1'b0}},
            // end at start expires at once, register comes back
            '{1'b0, 12'd0,    12'd4095, 12'hFFF, 1,  1'b1, '{12'hFFF, 6'd0, 1'b0, 1'b0}},
            '{1'b0, 12'd5,    12'd10,   12'h001, 1,  1'b1, '{12'h001, 6'd1, 1'b0, 1'b0}},
            // out-of-order start is flagged but still allocated
            '{1'b0, 12'd3,    12'd4,    12'h002, 1,  1'b1, '{12'h002, 6'd2, 1'b0, 1'b1}},
            '{1'b0, 12'd4095, 12'd4095, 12'h003, 1,  1'b0, '0},
            '{1'b0, 12'd4095, 12'd0,    12'h004, 1,  1'b0, '0},
            // first of run skips the order check; the backward start after it is flagged
            '{1'b1, 12'd4095, 12'd4095, 12'h555, 1,  1'b1, '{12'h555, 6'd0, 1'b0, 1'b0}},
            '{1'b0, 12'd0,    12'd4095, 12'hAAA, 1,  1'b1, '{12'hAAA, 6'd1, 1'b0, 1'b1}},
            // fill the active list with long-lived values
            '{1'b1, 12'd0,    12'd4095, 12'h100, 64, 1'b0, '0},
            '{1'b0, 12'd1,    12'd2,    12'hABC, 1,  1'b1, '{12'hABC, 6'd0, 1'b1, 1'b0}},
            '{1'b0, 12'd4094, 12'd4095, 12'h123, 1,  1'b1, '{12'h123, 6'd0, 1'b1, 1'b0}},
            // everything expires, free stack fills up
            '{1'b0, 12'd4095, 12'd100,  12'h321, 1,  1'b0, '0},
            '{1'b0, 12'd4095, 12'd4095, 12'h7FF, 1,  1'b0, '0},
            '{1'b1, 12'd10,   12'd20,   12'h800, 1,  1'b1, '{12'h800, 6'd0, 1'b0, 1'b0}},
            '{1'b0, 12'd10,   12'd30,   12'h801, 1,  1'b1, '{12'h801, 6'd1, 1'b0, 1'b0}},
            '{1'b0, 12'd20,   12'd40,   12'h802, 1,  1'b0, '0},
            '{1'b0, 12'd9,    12'd12,   12'h803, 1,  1'b0, '0}
        };
        hold_done  = 1'b0;
        drain_done = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (plan[r]) begin
            for (k = 0; k < plan[r].rep; k++) begin
                it.first_of_run   = plan[r].first && (k == 0);
                it.interval_start = plan[r].start_at;
                it.interval_end   = plan[r].end_at;
                it.interval_tag   = plan[r].tag + FIELD_W'(k);
                send_interval(it, plan[r].typed_ok, plan[r].typed);
            end
        end

        // random runs
        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal) begin
            if (!hold_done && items_sent >= random_goal - RANDOM_ITEMS + 600) begin
                // receiver holds off while the sender keeps pushing
                hold_asked++;
                steady_left = 40;
                hold_done   = 1'b1;
            end
            pick = $urandom_range(0, 39);
            kind = (pick < 26) ? RUN_SHORT :
                   (pick < 29) ? RUN_LONG :
                   (pick < 33) ? RUN_NOISE :
                   (pick < 38) ? RUN_BROKEN : RUN_DRAIN;
            if (!drain_done && items_sent >= random_goal - RANDOM_ITEMS + 1200) begin
                kind       = RUN_DRAIN;
                drain_done = 1'b1;
            end
            if (kind == RUN_DRAIN) begin
                // sender pauses until the block has delivered everything
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
                drains++;
            end else begin
                run_len = (kind == RUN_LONG)  ? $urandom_range(66, 100) :
                          (kind == RUN_NOISE) ? $urandom_range(1, 8) : $urandom_range(1, 40);
                cur_start = ($urandom_range(0, 3) == 0) ? $urandom_range(3000, FIELD_TOP)
                                                        : $urandom_range(0, 200);
                for (k = 0; k < run_len; k++) begin
                    it.first_of_run = (k == 0);
                    it.interval_tag = FIELD_W'($urandom_range(0, FIELD_TOP));
                    if (kind == RUN_NOISE) begin
                        it.first_of_run   = 1'($urandom_range(0, 1));
                        it.interval_start = FIELD_W'($urandom_range(0, FIELD_TOP));
                        it.interval_end   = FIELD_W'($urandom_range(0, FIELD_TOP));
                    end else begin
                        end_val = cur_start + ((kind == RUN_LONG) ?
                                  $urandom_range(200, FIELD_TOP) : $urandom_range(0, 12));
                        it.interval_start = FIELD_W'(cur_start);
                        it.interval_end   = FIELD_W'((end_val > FIELD_TOP) ? FIELD_TOP
                                                                           : end_val);
                        // broken runs: stray backward starts and misplaced run heads
                        if (kind == RUN_BROKEN && $urandom_range(0, 4) == 0) begin
                            it.first_of_run   = ($urandom_range(0, 7) == 0);
                            it.interval_start = FIELD_W'($urandom_range(0, FIELD_TOP));
                            it.interval_end   = FIELD_W'($urandom_range(0, FIELD_TOP));
                        end
                    end
                    send_interval(it, 1'b0, '0);
                    cur_start += $urandom_range(0, (kind == RUN_LONG) ? 1 : 4);
                    if (cur_start > FIELD_TOP) cur_start = FIELD_TOP;
                end
            end
        end

        // wind down
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("sent %0d intervals in directed and random runs, checked %0d results",
                 items_sent, results_checked);
        $display("saw %0d overflows, %0d out-of-order starts, %0d hold-offs, %0d drains",
                 overflow_seen, order_err_seen, hold_served, drains);
        if (mismatches == 0) begin
            $display("tb_linear_scan_register_allocator_unit: PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb_linear_scan_register_allocator_unit: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lsra_pkg.sv
rtl/core/lsra_ram.sv
rtl/core/lsra_front.sv
rtl/core/lsra_queue.sv
rtl/core/lsra_back.sv
rtl/core/linear_scan_register_allocator_unit.sv
rtl/core/lsra_checker.sv
test/tb_linear_scan_register_allocator_unit.sv
